>>> rtl/pidaw_pkg.sv
// Shared types and constants for the PID controller with anti-windup.
`timescale 1ns / 1ps
package pidaw_pkg;

   localparam int FracBitsDefault = 16;
   localparam int DataWidth       = 32;
   localparam int IntegWidth      = 48;
   localparam int CsrIndexWidth   = 3;

   // Register indexes
   localparam logic [CsrIndexWidth-1:0] CsrPropGain   = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CsrIntegGain  = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CsrDerivGain  = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CsrOutLow     = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CsrOutHigh    = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CsrWindup     = 3'd5;

   // Request kinds
   localparam logic ReqStep    = 1'b0;
   localparam logic ReqRestart = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_ERRDT,
      ST_INTEG,
      ST_PROP,
      ST_DERIV,
      ST_SUM,
      ST_OUT
   } state_type;

   // Divider start/finish handshake
   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

>>> rtl/pidaw_div.sv
// Restoring divider, one quotient bit per cycle, unsigned.
`timescale 1ns / 1ps
module pidaw_div
   import pidaw_pkg::*;
#(
   parameter int NumWidth = 48,
   parameter int DenWidth = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  div_ctrl_type        ctrl,
   input  logic [NumWidth-1:0] numer,
   input  logic [DenWidth-1:0] denom,
   output div_stat_type        stat,
   output logic [NumWidth-1:0] quot
);
   localparam int CntWidth = $clog2(NumWidth + 1);

   logic [NumWidth-1:0] quot_ff, quot_in;
   logic [DenWidth:0]   rem_ff, rem_in;
   logic [DenWidth-1:0] den_ff, den_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DenWidth:0]   trial;
   logic [DenWidth:0]   diff;

   // One shift-subtract step
   always_comb begin
      trial = {rem_ff[DenWidth-1:0], quot_ff[NumWidth-1]};
      diff  = trial - {1'b0, den_ff};
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         quot_in = numer;
         rem_in  = '0;
         den_in  = denom;
         cnt_in  = CntWidth'(NumWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DenWidth]) begin
            rem_in  = diff;
            quot_in = {quot_ff[NumWidth-2:0], 1'b1};
         end else begin
            rem_in  = trial;
            quot_in = {quot_ff[NumWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quot      = quot_ff;
endmodule

>>> rtl/pid_controller_anti_windup.sv
// Top level: PID step with derivative on measurement and optional anti-windup clamp.
//
//  channel | direction | contents
//  req     | in        | tuser: req_type; tdata: measurement[31:0], target[63:32],
//          |           |   time_step[95:64]
//  rsp     | out       | tdata: drive[31:0], dt_fault[32], zeros above
//  csr     | in        | write enable, index, 32-bit data
//
// A control step runs the divider start, the bit-serial division and the done strobe,
// then the states ERRDT, INTEG, PROP, DERIV, SUM and OUT for the shared multiplier and
// summing. A zero time step skips the divider. A restart has its result valid the cycle
// after its transfer. Reset is synchronous and clears configuration, state, integrator and
// previous measurement, not the datapath registers. req_tready is low while an item is at
// work or its result waits in the output register.
`timescale 1ns / 1ps
module pid_controller_anti_windup
   import pidaw_pkg::*;
#(
   parameter int FRAC_BITS = FracBitsDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [95:0]              req_tdata,   // measurement, target, time_step
   input  logic                     req_tuser,   // req_type
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [39:0]              rsp_tdata,   // drive, dt_fault, zero fill
   input  logic                     csr_wr_en,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [DataWidth-1:0]     csr_wdata
);
   localparam int NumWidth = DataWidth + 1 + FRAC_BITS;
   localparam int ProdWidth = 2 * DataWidth + 2;

   // Configuration registers
   logic signed [31:0] prop_gain_ff, integ_gain_ff, deriv_gain_ff, out_low_ff, out_high_ff;
   logic               windup_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff  <= '0;
         integ_gain_ff <= '0;
         deriv_gain_ff <= '0;
         out_low_ff    <= '0;
         out_high_ff   <= '0;
         windup_ff     <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CsrPropGain:  prop_gain_ff  <= csr_wdata;
            CsrIntegGain: integ_gain_ff <= csr_wdata;
            CsrDerivGain: deriv_gain_ff <= csr_wdata;
            CsrOutLow:    out_low_ff    <= csr_wdata;
            CsrOutHigh:   out_high_ff   <= csr_wdata;
            CsrWindup:    windup_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Sequencer and datapath registers
   state_type state_ff, state_in;
   logic signed [32:0] err_ff;          // target - measurement
   logic signed [32:0] diff_ff;         // measurement - prev
   logic [31:0]        dt_ff;
   logic               fault_ff;
   logic signed [31:0] prev_ff;
   logic signed [47:0] integ_ff;
   logic signed [32:0] opa_ff;          // shared multiplier operands (opb may be dt)
   logic signed [31:0] opb_ff;
   logic               opb_uns_ff;
   logic signed [31:0] rate_ff, errdt_ff;
   logic signed [49:0] pterm_ff;
   logic signed [49:0] acc_ff;
   logic               rsp_valid_ff;
   logic [31:0]        drive_ff;
   logic               dfault_ff;
   logic               div_go_ff;
   logic [31:0]        req_meas_ff;

   // Shared multiplier: magnitudes, Q shift, sign restore
   logic [32:0]        mag_a, mag_b;
   logic [65:0]        mprod;
   logic [65:0]        mshift;
   logic signed [ProdWidth-1:0] mres;
   logic               mneg;
   always_comb begin
      mag_a = opa_ff[32] ? 33'(-opa_ff) : 33'(opa_ff);
      if (opb_uns_ff)
         mag_b = {1'b0, opb_ff};
      else
         mag_b = opb_ff[31] ? 33'(-{opb_ff[31], opb_ff}) : {1'b0, opb_ff};
      mneg   = opa_ff[32] ^ (opb_ff[31] & !opb_uns_ff);
      mprod  = 66'(mag_a * mag_b);
      mshift = mprod >> FRAC_BITS;
      mres   = mneg ? -$signed(mshift) : $signed(mshift);
   end

   // Divider for |diff| << FRAC_BITS / dt
   div_ctrl_type       dctrl;
   div_stat_type       dstat;
   logic [NumWidth-1:0] dnum, dquot;
   logic [32:0]        dmag;
   assign dmag = diff_ff[32] ? 33'(-diff_ff) : 33'(diff_ff);
   assign dnum = NumWidth'(dmag) << FRAC_BITS;
   assign dctrl.start = (state_ff == ST_DIV) && !dstat.busy && !dstat.done && !fault_ff
                        && !div_go_ff;

   pidaw_div #(.NumWidth(NumWidth), .DenWidth(DataWidth)) u_div (
      .clock (clock),
      .reset (reset),
      .ctrl  (dctrl),
      .numer (dnum),
      .denom (dt_ff),
      .stat  (dstat),
      .quot  (dquot)
   );

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      if (x > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
      else if (x < -64'sh80000000) return 32'sh80000000;
      else return x[31:0];
   endfunction

   // Signed rate from quotient, saturated to 32 bits
   logic signed [31:0] rate_val;
   always_comb begin
      if (dquot > NumWidth'(32'h7FFFFFFF))
         rate_val = diff_ff[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
      else
         rate_val = diff_ff[32] ? -$signed(dquot[31:0]) : $signed(dquot[31:0]);
   end

   // Clamps
   logic signed [49:0] lo_ext, hi_ext;
   assign lo_ext = 50'(out_low_ff);
   assign hi_ext = 50'(out_high_ff);
   function automatic logic signed [49:0] clampv(input logic signed [49:0] x,
         input logic signed [49:0] lo, input logic signed [49:0] hi);
      logic signed [49:0] y;
      y = (x > hi) ? hi : x;
      return (y < lo) ? lo : y;
   endfunction

   logic signed [49:0] isum_next;
   logic signed [49:0] ival, outv;
   always_comb begin
      isum_next = 50'(integ_ff) + 50'(mres);
      ival = windup_ff ? clampv(50'(integ_ff), lo_ext, hi_ext) : 50'(integ_ff);
      outv = windup_ff ? clampv(acc_ff, lo_ext, hi_ext) : acc_ff;
   end

   // Next state
   logic req_fire, rsp_fire;
   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && !rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_fire && req_tuser == ReqStep) state_in = ST_DIV;
         ST_DIV:   if (fault_ff || dstat.done) state_in = ST_ERRDT;
         ST_ERRDT: state_in = ST_INTEG;
         ST_INTEG: state_in = ST_PROP;
         ST_PROP:  state_in = ST_DERIV;
         ST_DERIV: state_in = ST_SUM;
         ST_SUM:   state_in = ST_OUT;
         ST_OUT:   state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         prev_ff      <= '0;
         integ_ff     <= '0;
         div_go_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         div_go_ff <= dctrl.start ? 1'b1 : (state_ff == ST_DIV ? div_go_ff : 1'b0);
         if (rsp_fire) rsp_valid_ff <= 1'b0;
         if (req_fire && req_tuser == ReqRestart) begin
            prev_ff      <= '0;
            integ_ff     <= '0;
            rsp_valid_ff <= 1'b1;
         end
         if (state_ff == ST_ERRDT) prev_ff <= $signed(req_meas_ff);
         if (state_ff == ST_PROP) begin
            if (isum_next > 50'sh7FFFFFFFFFFF) integ_ff <= 48'sh7FFFFFFFFFFF;
            else if (isum_next < -50'sh800000000000) integ_ff <= 48'sh800000000000;
            else integ_ff <= isum_next[47:0];
         end
         if (state_ff == ST_OUT) rsp_valid_ff <= 1'b1;
      end
   end

   // Datapath operand steering per state
   always_ff @(posedge clock) begin
      if (req_fire) begin
         req_meas_ff <= req_tdata[31:0];
         err_ff   <= 33'($signed(req_tdata[63:32])) - 33'($signed(req_tdata[31:0]));
         diff_ff  <= 33'($signed(req_tdata[31:0])) - 33'(prev_ff);
         dt_ff    <= req_tdata[95:64];
         fault_ff <= (req_tdata[95:64] == '0);
         drive_ff  <= '0;
         dfault_ff <= 1'b0;
      end
      case (state_ff)
         ST_DIV: begin
            rate_ff <= fault_ff ? '0 : rate_val;
            // full 33-bit error times unsigned dt
            opa_ff     <= err_ff;
            opb_ff     <= dt_ff;
            opb_uns_ff <= 1'b1;
         end
         ST_ERRDT: begin
            errdt_ff   <= sat32(64'(mres));
            opb_uns_ff <= 1'b0;
         end
         ST_INTEG: begin
            opa_ff <= 33'(integ_gain_ff);
            opb_ff <= errdt_ff;
         end
         ST_PROP: begin
            opa_ff <= err_ff;
            opb_ff <= prop_gain_ff;
         end
         ST_DERIV: begin
            pterm_ff <= 50'(mres);
            opa_ff   <= 33'(deriv_gain_ff);
            opb_ff   <= rate_ff;
         end
         ST_SUM: begin
            acc_ff <= pterm_ff + ival - 50'(mres);
         end
         ST_OUT: begin
            drive_ff  <= sat32(64'(outv));
            dfault_ff <= fault_ff;
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, dfault_ff, drive_ff};

`ifndef NO_ASSERTIONS
   // No new request while a result waits
   a_no_accept_while_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req_tready)
      else $error("request accepted while result pending");
   // A held result stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped before transfer");
   // A zero time step never starts the divider
   a_fault_no_div: assert property (@(posedge clock) disable iff (reset)
      dctrl.start |-> !fault_ff)
      else $error("divider started on zero time step");
`endif
endmodule
